// ===== rtl/int64_shift_subtract_divider_macros.svh =====
// ----------------------------------------------------------------------------
// int64_shift_subtract_divider assertion macros
// Clocked, reset-qualified assertion helpers used by the divider controller.
// ----------------------------------------------------------------------------
`ifndef INT64_SHIFT_SUBTRACT_DIVIDER_MACROS_SVH
`define INT64_SHIFT_SUBTRACT_DIVIDER_MACROS_SVH

// property checked on every rising clk_i edge outside reset
`define I64DIV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression that must never hold outside reset
`define I64DIV_ASSERT_NEVER(lbl, expr, msg) \
  `I64DIV_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/i64div_pkg.sv =====
// ----------------------------------------------------------------------------
// i64div_pkg
// Shared widths and controller/datapath interface types of the divider.
// ----------------------------------------------------------------------------
package i64div_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic load;   // capture operands
    logic neg;    // take magnitudes
    logic step;   // one restoring step
    logic fix;    // sign fix-up into output register
  } i64div_cmd_t;

  typedef struct packed {
    logic dbz;    // divisor is zero
  } i64div_sts_t;

endpackage

// ===== rtl/i64div_ctrl.sv =====
// ----------------------------------------------------------------------------
// i64div_ctrl
// Sequencer of the divider: operand load, magnitude, step count, result hand-off.
// ----------------------------------------------------------------------------
`include "int64_shift_subtract_divider_macros.svh"

module i64div_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output i64div_pkg::i64div_cmd_t  cmd_o,
  input  i64div_pkg::i64div_sts_t  sts_i
);
  import i64div_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NEG,
    S_DIV,
    S_FIX
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             last_step;
  logic             slot_free;

  assign last_step = (cnt_q == CNT_W'(DATA_WIDTH - 1));
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_NEG;
        end
      end
      S_NEG: begin
        cmd_o.neg = 1'b1;
        cnt_d     = '0;
        state_d   = sts_i.dbz ? S_FIX : S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        if (last_step) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (slot_free) begin
          cmd_o.fix   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `I64DIV_ASSERT(a_load_then_neg, cmd_o.load |=> cmd_o.neg, "load not followed by magnitude")
  `I64DIV_ASSERT(a_last_to_fix, (cmd_o.step && last_step) |=> (state_q == S_FIX), "step count overrun")
  `I64DIV_ASSERT(a_valid_from_fix, $rose(out_valid_q) |-> $past(cmd_o.fix), "result without fix-up")
  `I64DIV_ASSERT_NEVER(a_fix_overwrite, cmd_o.fix && out_valid_q && out_stall_i, "result overwritten")

endmodule

// ===== rtl/i64div_dpath.sv =====
// ----------------------------------------------------------------------------
// i64div_dpath
// Operand magnitudes, restoring shift-subtract datapath and result register.
// ----------------------------------------------------------------------------
module i64div_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  i64div_pkg::i64div_cmd_t            cmd_i,
  output i64div_pkg::i64div_sts_t            sts_o,
  input  logic                               opcode_i,
  input  logic [i64div_pkg::DATA_WIDTH-1:0]  dividend_i,
  input  logic [i64div_pkg::DATA_WIDTH-1:0]  divisor_i,
  output logic [i64div_pkg::DATA_WIDTH-1:0]  quotient_o,
  output logic [i64div_pkg::DATA_WIDTH-1:0]  remainder_o,
  output logic                               divide_by_zero_o
);
  import i64div_pkg::*;

  logic [DATA_WIDTH-1:0] num_q, den_q, rem_q;
  logic                  sgn_q, num_neg_q, den_neg_q, dbz_q;
  logic [DATA_WIDTH-1:0] quot_q, remo_q;
  logic                  dbzo_q;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  ge;
  logic [DATA_WIDTH-1:0] quot_fix, rem_fix;

  // partial remainder is below the divisor, so shifted fits in W+1 bits
  assign shifted = {rem_q, num_q[DATA_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !diff[DATA_WIDTH+1];

  assign quot_fix = (sgn_q && (num_neg_q != den_neg_q)) ? ('0 - num_q) : num_q;
  assign rem_fix  = (sgn_q && num_neg_q) ? ('0 - rem_q) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbz_q  <= 1'b0;
      dbzo_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        dbz_q <= (divisor_i == '0);
      end
      if (cmd_i.fix) begin
        dbzo_q <= dbz_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q     <= dividend_i;
      den_q     <= divisor_i;
      rem_q     <= '0;
      sgn_q     <= opcode_i;
      num_neg_q <= 1'b0;
      den_neg_q <= 1'b0;
    end
    if (cmd_i.neg && sgn_q) begin
      num_neg_q <= num_q[DATA_WIDTH-1];
      den_neg_q <= den_q[DATA_WIDTH-1];
      if (num_q[DATA_WIDTH-1]) begin
        num_q <= '0 - num_q;
      end
      if (den_q[DATA_WIDTH-1]) begin
        den_q <= '0 - den_q;
      end
    end
    if (cmd_i.step) begin
      num_q <= {num_q[DATA_WIDTH-2:0], ge};
      rem_q <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    end
    if (cmd_i.fix) begin
      quot_q <= dbz_q ? '0 : quot_fix;
      remo_q <= dbz_q ? '0 : rem_fix;
    end
  end

  assign sts_o.dbz        = dbz_q;
  assign quotient_o       = quot_q;
  assign remainder_o      = remo_q;
  assign divide_by_zero_o = dbzo_q;

endmodule

// ===== rtl/int64_shift_subtract_divider.sv =====
// ----------------------------------------------------------------------------
// int64_shift_subtract_divider
// 64-bit signed/unsigned radix-2 restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o | opcode_i, dividend_i, divisor_i
//  out     | out_valid_o/out_stall_i | quotient_o, remainder_o, divide_by_zero_o
//
//  After accept: 1 magnitude, 64 shift-subtract, 1 fix-up step (waits on a stall).
//  A new item is taken only when idle; the single subtractor loop sets this.
//  Zero divisor skips the loop: magnitude goes straight to fix-up.
//  The result register frees the input side: a stalled result blocks only fix-up.
//  Asynchronous active-low reset clears control, zero-divisor flags and output valid.
// ----------------------------------------------------------------------------
module int64_shift_subtract_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [i64div_pkg::DATA_WIDTH-1:0]  dividend_i,
  input  logic [i64div_pkg::DATA_WIDTH-1:0]  divisor_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [i64div_pkg::DATA_WIDTH-1:0]  quotient_o,
  output logic [i64div_pkg::DATA_WIDTH-1:0]  remainder_o,
  output logic                               divide_by_zero_o
);
  import i64div_pkg::*;

  i64div_cmd_t cmd;
  i64div_sts_t sts;

  i64div_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  i64div_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .dividend_i       (dividend_i),
    .divisor_i        (divisor_i),
    .quotient_o       (quotient_o),
    .remainder_o      (remainder_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule
